// ----- rtl/ctt_pkg.sv -----
// Shared types, character codes and helpers of the config text tokenizer.
package ctt_pkg;

    // Default sizing of the source text and of the indent counter.
    localparam longint unsigned MAX_SOURCE_BYTES = 64'd65536;
    localparam int unsigned     MAX_INDENT       = 255;

    // Field widths.
    localparam int unsigned POS_W  = 16;
    localparam int unsigned LINE_W = 16;
    localparam int unsigned IND_W  = 8;
    localparam int unsigned KIND_W = 4;

    // Largest number of results one item can cause.
    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned CNT_W       = 2;

    // Line and column counters saturate here.
    localparam logic [LINE_W-1:0] LINE_LIMIT = 16'hFFFF;

    // Character codes.
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Scanner modes, one-hot.
    typedef enum logic [5:0] {
        MODE_NORMAL  = 6'b000001,
        MODE_COMMENT = 6'b000010,
        MODE_INDENT  = 6'b000100,
        MODE_KEY     = 6'b001000,
        MODE_QUOTE   = 6'b010000,
        MODE_ESCAPE  = 6'b100000
    } t_mode;

    // Which quote character opened the current quoted token.
    typedef enum logic [1:0] {
        QD_NONE     = 2'd0,
        QD_DOUBLE   = 2'd1,
        QD_SINGLE   = 2'd2,
        QD_BACKTICK = 2'd3
    } t_qdelim;

    // Token kinds on the result channel.
    typedef enum logic [KIND_W-1:0] {
        TK_END        = 4'd0,
        TK_KEY        = 4'd1,
        TK_QKEY       = 4'd2,
        TK_STRING     = 4'd3,
        TK_MAP_OPEN   = 4'd4,
        TK_MAP_CLOSE  = 4'd5,
        TK_LIST_OPEN  = 4'd6,
        TK_LIST_CLOSE = 4'd7,
        TK_UNCLOSED   = 4'd8
    } t_kind;

    // One input item.
    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic [POS_W-1:0]  start_offset;
        logic [POS_W-1:0]  end_offset;
        logic [IND_W-1:0]  line_indent;
        logic [LINE_W-1:0] error_line;
        logic [LINE_W-1:0] error_column;
        logic              final_result;
    } t_out_item;

    // The results caused by one input item, in order.
    typedef struct packed {
        logic [CNT_W-1:0]                  count;
        t_out_item [MAX_RESULTS-1:0]       items;
    } t_group;

    // Scanner state.
    typedef struct packed {
        t_mode             mode;
        t_qdelim           qdelim;
        logic [POS_W-1:0]  token_begin;
        logic [POS_W-1:0]  byte_position;
        logic [IND_W-1:0]  indent_count;
        logic [LINE_W-1:0] line_number;
        logic [LINE_W-1:0] column_number;
        logic [LINE_W-1:0] quote_line;
        logic [LINE_W-1:0] quote_column;
    } t_scan_state;

    // State at reset and after the final result of a text.
    function automatic t_scan_state scan_reset();
        t_scan_state s;
        s.mode          = MODE_NORMAL;
        s.qdelim        = QD_NONE;
        s.token_begin   = '0;
        s.byte_position = '0;
        s.indent_count  = '0;
        s.line_number   = 16'd1;
        s.column_number = 16'd1;
        s.quote_line    = 16'd1;
        s.quote_column  = 16'd1;
        return s;
    endfunction

    // Saturating increments.
    function automatic logic [15:0] sat_inc16(input logic [15:0] v, input logic [15:0] lim);
        return (v >= lim) ? lim : v + 16'd1;
    endfunction

    function automatic logic [7:0] sat_inc8(input logic [7:0] v, input logic [7:0] lim);
        return (v >= lim) ? lim : v + 8'd1;
    endfunction

    // Bytes that end a bare key.
    function automatic logic is_key_delim(input logic [7:0] b);
        return (b == CH_SEMI)   || (b == CH_LBRACE) || (b == CH_LBRACK) ||
               (b == CH_RBRACK) || (b == CH_RBRACE) || (b == CH_DQUOTE) ||
               (b == CH_SQUOTE) || (b == CH_LF)     || (b == CH_CR)     ||
               (b == CH_TAB)    || (b == CH_SPACE);
    endfunction

endpackage

// ----- rtl/ctt_in_if.sv -----
// Input channel of the tokenizer: one source byte per item.
interface ctt_in_if;
    logic              valid;
    logic              ready;
    ctt_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ctt_out_if.sv -----
// Result channel of the tokenizer: one token or final result per item.
interface ctt_out_if;
    logic               valid;
    logic               ready;
    ctt_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ctt_scan.sv -----
// Scanner state and the per-byte logic that forms the results of one item.
module ctt_scan #(
    parameter longint unsigned MAX_SOURCE_BYTES = ctt_pkg::MAX_SOURCE_BYTES,
    parameter int unsigned     MAX_INDENT       = ctt_pkg::MAX_INDENT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  ctt_pkg::t_in_item i_item,
    output ctt_pkg::t_group   o_group
);

    // Saturation limits of the offsets and of the indent.
    localparam logic [ctt_pkg::POS_W-1:0] POS_LIMIT =
        (MAX_SOURCE_BYTES - 64'd1 > 64'd65535) ? 16'hFFFF : 16'(MAX_SOURCE_BYTES - 64'd1);
    localparam logic [ctt_pkg::IND_W-1:0] IND_LIMIT =
        (MAX_INDENT > 255) ? 8'hFF : 8'(MAX_INDENT);

    ctt_pkg::t_scan_state r_state;
    ctt_pkg::t_scan_state n_state;

    logic [7:0]                  b;
    logic [7:0]                  qchar;
    logic [ctt_pkg::POS_W-1:0]   p1;
    logic                        is_ws;
    logic                        run_norm;
    logic                        key_emit;
    logic                        quote_emit;
    logic                        brace_emit;
    ctt_pkg::t_kind              brace_kind;
    logic                        open_quote;
    logic [3:0]                  cand_v;
    ctt_pkg::t_out_item [3:0]    cand;
    logic [ctt_pkg::CNT_W-1:0]   cnt;

    // Next state and the candidate results of the current byte.
    always_comb begin
        b          = i_item.char_byte;
        n_state    = r_state;
        is_ws      = (b == ctt_pkg::CH_SPACE) || (b == ctt_pkg::CH_TAB);
        p1         = ctt_pkg::sat_inc16(r_state.byte_position, POS_LIMIT);
        run_norm   = 1'b0;
        key_emit   = 1'b0;
        quote_emit = 1'b0;
        brace_emit = 1'b0;
        brace_kind = ctt_pkg::TK_MAP_OPEN;

        case (r_state.qdelim)
            ctt_pkg::QD_DOUBLE: qchar = ctt_pkg::CH_DQUOTE;
            ctt_pkg::QD_SINGLE: qchar = ctt_pkg::CH_SQUOTE;
            default:            qchar = ctt_pkg::CH_BTICK;
        endcase

        // Mode-specific handling; some paths fall through to normal handling.
        case (r_state.mode)
            ctt_pkg::MODE_COMMENT: begin
                run_norm = (b == ctt_pkg::CH_LF);
            end
            ctt_pkg::MODE_INDENT: begin
                if (is_ws) begin
                    n_state.indent_count = ctt_pkg::sat_inc8(r_state.indent_count, IND_LIMIT);
                end else begin
                    run_norm = 1'b1;
                end
            end
            ctt_pkg::MODE_KEY: begin
                if (ctt_pkg::is_key_delim(b)) begin
                    key_emit = 1'b1;
                    run_norm = 1'b1;
                end
            end
            ctt_pkg::MODE_QUOTE: begin
                if (b == ctt_pkg::CH_BSLASH) begin
                    n_state.mode = ctt_pkg::MODE_ESCAPE;
                end else if (b == qchar) begin
                    quote_emit   = 1'b1;
                    n_state.mode = ctt_pkg::MODE_NORMAL;
                end
            end
            ctt_pkg::MODE_ESCAPE: begin
                n_state.mode = ctt_pkg::MODE_QUOTE;
            end
            default: begin
                run_norm = 1'b1;
            end
        endcase

        // Normal handling of the byte.
        if (run_norm) begin
            n_state.mode = ctt_pkg::MODE_NORMAL;
            case (b)
                ctt_pkg::CH_LBRACE: begin
                    brace_emit = 1'b1;
                    brace_kind = ctt_pkg::TK_MAP_OPEN;
                end
                ctt_pkg::CH_RBRACE: begin
                    brace_emit = 1'b1;
                    brace_kind = ctt_pkg::TK_MAP_CLOSE;
                end
                ctt_pkg::CH_LBRACK: begin
                    brace_emit = 1'b1;
                    brace_kind = ctt_pkg::TK_LIST_OPEN;
                end
                ctt_pkg::CH_RBRACK: begin
                    brace_emit = 1'b1;
                    brace_kind = ctt_pkg::TK_LIST_CLOSE;
                end
                ctt_pkg::CH_DQUOTE, ctt_pkg::CH_SQUOTE, ctt_pkg::CH_BTICK: begin
                    n_state.qdelim       = (b == ctt_pkg::CH_DQUOTE) ? ctt_pkg::QD_DOUBLE :
                                           (b == ctt_pkg::CH_SQUOTE) ? ctt_pkg::QD_SINGLE :
                                                                       ctt_pkg::QD_BACKTICK;
                    n_state.token_begin  = p1;
                    n_state.quote_line   = r_state.line_number;
                    n_state.quote_column = r_state.column_number;
                    n_state.mode         = ctt_pkg::MODE_QUOTE;
                end
                ctt_pkg::CH_SPACE, ctt_pkg::CH_TAB, ctt_pkg::CH_CR: begin
                end
                ctt_pkg::CH_LF: begin
                    n_state.indent_count = '0;
                    n_state.mode         = ctt_pkg::MODE_INDENT;
                end
                ctt_pkg::CH_SEMI: begin
                    n_state.mode = ctt_pkg::MODE_COMMENT;
                end
                default: begin
                    n_state.token_begin = r_state.byte_position;
                    n_state.mode        = ctt_pkg::MODE_KEY;
                end
            endcase
        end

        // Line and column tracking.
        if (b == ctt_pkg::CH_LF) begin
            n_state.line_number   = ctt_pkg::sat_inc16(r_state.line_number, ctt_pkg::LINE_LIMIT);
            n_state.column_number = 16'd1;
        end else begin
            n_state.column_number = ctt_pkg::sat_inc16(r_state.column_number,
                                                       ctt_pkg::LINE_LIMIT);
        end

        open_quote = (n_state.mode == ctt_pkg::MODE_QUOTE) ||
                     (n_state.mode == ctt_pkg::MODE_ESCAPE);

        // Closed key or quoted token.
        cand_v[0]               = key_emit || quote_emit;
        cand[0]                 = '0;
        cand[0].token_kind      = key_emit ? ctt_pkg::TK_KEY :
                                  (r_state.qdelim == ctt_pkg::QD_BACKTICK) ? ctt_pkg::TK_QKEY :
                                                                             ctt_pkg::TK_STRING;
        cand[0].start_offset    = r_state.token_begin;
        cand[0].end_offset      = r_state.byte_position;
        cand[0].line_indent     = r_state.indent_count;

        // Brace or bracket.
        cand_v[1]               = brace_emit;
        cand[1]                 = '0;
        cand[1].token_kind      = brace_kind;
        cand[1].start_offset    = r_state.byte_position;
        cand[1].end_offset      = p1;
        cand[1].line_indent     = r_state.indent_count;

        // Bare key still open at the final byte.
        cand_v[2]               = i_item.last_byte && !open_quote &&
                                  (n_state.mode == ctt_pkg::MODE_KEY);
        cand[2]                 = '0;
        cand[2].token_kind      = ctt_pkg::TK_KEY;
        cand[2].start_offset    = n_state.token_begin;
        cand[2].end_offset      = p1;
        cand[2].line_indent     = n_state.indent_count;

        // End token, or the error result for an open quote.
        cand_v[3]               = i_item.last_byte;
        cand[3]                 = '0;
        cand[3].final_result    = 1'b1;
        if (open_quote) begin
            cand[3].token_kind   = ctt_pkg::TK_UNCLOSED;
            cand[3].error_line   = n_state.quote_line;
            cand[3].error_column = n_state.quote_column;
        end else begin
            cand[3].token_kind   = ctt_pkg::TK_END;
        end

        // A final result starts the next text from the reset state.
        if (i_item.last_byte) begin
            n_state = ctt_pkg::scan_reset();
        end else begin
            n_state.byte_position = p1;
        end

        // Pack the candidates in order into the result group.
        cnt           = '0;
        o_group.items = '0;
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i] && (cnt < ctt_pkg::CNT_W'(ctt_pkg::MAX_RESULTS))) begin
                o_group.items[cnt] = cand[i];
                cnt                = cnt + ctt_pkg::CNT_W'(1);
            end
        end
        o_group.count = cnt;
    end

    // State register, updated once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctt_pkg::scan_reset();
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/ctt_outbuf.sv -----
// Result register: holds the results of one item and hands them out one per cycle while o_out is ready.
module ctt_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ctt_pkg::t_group  i_group,
    output logic             o_free,
    ctt_out_if.source        o_out
);

    ctt_pkg::t_out_item [ctt_pkg::MAX_RESULTS-1:0] r_items;
    logic [ctt_pkg::CNT_W-1:0]                     r_left;
    logic                                          take;

    assign take        = o_out.valid && o_out.ready;
    assign o_out.valid = (r_left != '0);
    assign o_out.data  = r_items[0];

    // A new group may enter once the last held result leaves.
    assign o_free = (r_left == '0) || ((r_left == ctt_pkg::CNT_W'(1)) && o_out.ready);

    // Count of results still to deliver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= i_group.count;
        end else if (take) begin
            r_left <= r_left - ctt_pkg::CNT_W'(1);
        end
    end

    // Result slots; the head slot drives the channel.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_items <= i_group.items;
        end else if (take) begin
            for (int i = 0; i < ctt_pkg::MAX_RESULTS - 1; i++) begin
                r_items[i] <= r_items[i+1];
            end
        end
    end

endmodule

// ----- rtl/config_text_tokenizer.sv -----
// Top level of the config text tokenizer: input register, scanner and result register.
//
//  Port      Dir  Carries                         Accepted when
//  i_in      in   char_byte, last_byte            i_in.valid && i_in.ready
//  o_out     out  token kind, offsets, indent,    o_out.valid && o_out.ready
//                 error line/column, final flag
//
// Each byte passes the input register, then the scanner logic, and its results
// land in the result register. While o_out is ready, a byte that causes one
// result or none is taken every cycle; a byte that causes two or three results
// holds the input until the result register has handed them out.
// Reset is synchronous, active low, and returns the scanner to line 1, column 1.
// A stall on o_out backs up into the input register and then into i_in.ready.
module config_text_tokenizer #(
    parameter longint unsigned MAX_SOURCE_BYTES = ctt_pkg::MAX_SOURCE_BYTES,
    parameter int unsigned     MAX_INDENT       = ctt_pkg::MAX_INDENT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ctt_in_if.sink     i_in,
    ctt_out_if.source  o_out
);

    logic              r_in_valid;
    ctt_pkg::t_in_item r_in;
    logic              buf_free;
    logic              advance;
    ctt_pkg::t_group   group;

    assign advance    = r_in_valid && buf_free;
    assign i_in.ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    // Scanner state and per-byte logic.
    ctt_scan #(
        .MAX_SOURCE_BYTES (MAX_SOURCE_BYTES),
        .MAX_INDENT       (MAX_INDENT)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_in),
        .o_group (group)
    );

    // Result register and serializer.
    ctt_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_group (group),
        .o_free  (buf_free),
        .o_out   (o_out)
    );

endmodule

// ----- verif/config_text_tokenizer_tb.sv -----
// Self-checking testbench of the config text tokenizer, with its token scoreboard.
package ctt_scoreboard_pkg;

    // Saturation points of offsets, line and column, and indent.
    localparam longint unsigned OFFSET_CAP_WIDE =
        (ctt_pkg::MAX_SOURCE_BYTES - 1 > 65535) ? 65535 : ctt_pkg::MAX_SOURCE_BYTES - 1;
    localparam logic [15:0] OFFSET_CAP = 16'(OFFSET_CAP_WIDE);
    localparam logic [15:0] LINE_CAP   = 16'hFFFF;
    localparam logic [7:0]  INDENT_CAP =
        (ctt_pkg::MAX_INDENT > 255) ? 8'd255 : 8'(ctt_pkg::MAX_INDENT);

    // Bytes that close a bare key.
    function automatic logic ends_key(input logic [7:0] c);
        return c inside {ctt_pkg::CH_SEMI, ctt_pkg::CH_LBRACE, ctt_pkg::CH_LBRACK,
                         ctt_pkg::CH_RBRACK, ctt_pkg::CH_RBRACE, ctt_pkg::CH_DQUOTE,
                         ctt_pkg::CH_SQUOTE, ctt_pkg::CH_LF, ctt_pkg::CH_CR,
                         ctt_pkg::CH_TAB, ctt_pkg::CH_SPACE};
    endfunction

    // Tracks the scanner state and holds the tokens still to come out.
    class token_scoreboard;
        ctt_pkg::t_scan_state st;
        ctt_pkg::t_out_item   pending[$];
        int unsigned          mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            st.mode          = ctt_pkg::MODE_NORMAL;
            st.qdelim        = ctt_pkg::QD_NONE;
            st.token_begin   = '0;
            st.byte_position = '0;
            st.indent_count  = '0;
            st.line_number   = 16'd1;
            st.column_number = 16'd1;
            st.quote_line    = 16'd1;
            st.quote_column  = 16'd1;
        endfunction

        function logic [15:0] bump16(input logic [15:0] v, input logic [15:0] cap);
            return (v >= cap) ? cap : v + 16'd1;
        endfunction

        function void push_token(input ctt_pkg::t_kind kind, input logic [15:0] first,
                                 input logic [15:0] past, input logic [7:0] ind,
                                 input logic [15:0] eline, input logic [15:0] ecol,
                                 input logic fin);
            ctt_pkg::t_out_item t;
            t.token_kind   = kind;
            t.start_offset = first;
            t.end_offset   = past;
            t.line_indent  = ind;
            t.error_line   = eline;
            t.error_column = ecol;
            t.final_result = fin;
            pending.push_back(t);
        endfunction

        // A byte seen outside any key, quote or comment.
        function void scan_plain(input logic [7:0] b);
            logic [15:0] here;
            logic [15:0] next;
            here = st.byte_position;
            next = bump16(here, OFFSET_CAP);
            case (b)
                ctt_pkg::CH_LBRACE: push_token(ctt_pkg::TK_MAP_OPEN, here, next,
                                               st.indent_count, '0, '0, 1'b0);
                ctt_pkg::CH_RBRACE: push_token(ctt_pkg::TK_MAP_CLOSE, here, next,
                                               st.indent_count, '0, '0, 1'b0);
                ctt_pkg::CH_LBRACK: push_token(ctt_pkg::TK_LIST_OPEN, here, next,
                                               st.indent_count, '0, '0, 1'b0);
                ctt_pkg::CH_RBRACK: push_token(ctt_pkg::TK_LIST_CLOSE, here, next,
                                               st.indent_count, '0, '0, 1'b0);
                ctt_pkg::CH_DQUOTE, ctt_pkg::CH_SQUOTE, ctt_pkg::CH_BTICK: begin
                    if (b == ctt_pkg::CH_DQUOTE)
                        st.qdelim = ctt_pkg::QD_DOUBLE;
                    else if (b == ctt_pkg::CH_SQUOTE)
                        st.qdelim = ctt_pkg::QD_SINGLE;
                    else
                        st.qdelim = ctt_pkg::QD_BACKTICK;
                    st.token_begin  = next;
                    st.quote_line   = st.line_number;
                    st.quote_column = st.column_number;
                    st.mode         = ctt_pkg::MODE_QUOTE;
                end
                ctt_pkg::CH_SPACE, ctt_pkg::CH_TAB, ctt_pkg::CH_CR: begin
                end
                ctt_pkg::CH_LF: begin
                    st.indent_count = '0;
                    st.mode         = ctt_pkg::MODE_INDENT;
                end
                ctt_pkg::CH_SEMI: st.mode = ctt_pkg::MODE_COMMENT;
                default: begin
                    st.token_begin = here;
                    st.mode        = ctt_pkg::MODE_KEY;
                end
            endcase
        endfunction

        // Works out the tokens that one accepted input item causes.
        function void note_byte(input logic [7:0] b, input logic last);
            logic [7:0] closer;
            case (st.mode)
                ctt_pkg::MODE_COMMENT: begin
                    // The newline that ends a comment counts as a newline.
                    if (b == ctt_pkg::CH_LF)
                        scan_plain(b);
                end
                ctt_pkg::MODE_INDENT: begin
                    if (b == ctt_pkg::CH_SPACE || b == ctt_pkg::CH_TAB) begin
                        st.indent_count = (st.indent_count >= INDENT_CAP) ?
                                          INDENT_CAP : st.indent_count + 8'd1;
                    end else begin
                        st.mode = ctt_pkg::MODE_NORMAL;
                        scan_plain(b);
                    end
                end
                ctt_pkg::MODE_KEY: begin
                    // The delimiter closes the key and is then scanned as usual.
                    if (ends_key(b)) begin
                        push_token(ctt_pkg::TK_KEY, st.token_begin, st.byte_position,
                                   st.indent_count, '0, '0, 1'b0);
                        st.mode = ctt_pkg::MODE_NORMAL;
                        scan_plain(b);
                    end
                end
                ctt_pkg::MODE_QUOTE: begin
                    if (st.qdelim == ctt_pkg::QD_DOUBLE)
                        closer = ctt_pkg::CH_DQUOTE;
                    else if (st.qdelim == ctt_pkg::QD_SINGLE)
                        closer = ctt_pkg::CH_SQUOTE;
                    else
                        closer = ctt_pkg::CH_BTICK;
                    if (b == ctt_pkg::CH_BSLASH) begin
                        st.mode = ctt_pkg::MODE_ESCAPE;
                    end else if (b == closer) begin
                        if (st.qdelim == ctt_pkg::QD_BACKTICK)
                            push_token(ctt_pkg::TK_QKEY, st.token_begin, st.byte_position,
                                       st.indent_count, '0, '0, 1'b0);
                        else
                            push_token(ctt_pkg::TK_STRING, st.token_begin, st.byte_position,
                                       st.indent_count, '0, '0, 1'b0);
                        st.mode = ctt_pkg::MODE_NORMAL;
                    end
                end
                ctt_pkg::MODE_ESCAPE: st.mode = ctt_pkg::MODE_QUOTE;
                default: begin
                    st.mode = ctt_pkg::MODE_NORMAL;
                    scan_plain(b);
                end
            endcase

            if (b == ctt_pkg::CH_LF) begin
                st.line_number   = bump16(st.line_number, LINE_CAP);
                st.column_number = 16'd1;
            end else begin
                st.column_number = bump16(st.column_number, LINE_CAP);
            end

            // The final byte closes the text and clears the scanner.
            if (last) begin
                if (st.mode == ctt_pkg::MODE_QUOTE || st.mode == ctt_pkg::MODE_ESCAPE) begin
                    push_token(ctt_pkg::TK_UNCLOSED, '0, '0, '0, st.quote_line,
                               st.quote_column, 1'b1);
                end else begin
                    if (st.mode == ctt_pkg::MODE_KEY)
                        push_token(ctt_pkg::TK_KEY, st.token_begin,
                                   bump16(st.byte_position, OFFSET_CAP),
                                   st.indent_count, '0, '0, 1'b0);
                    push_token(ctt_pkg::TK_END, '0, '0, '0, '0, '0, 1'b1);
                end
                restart();
            end else begin
                st.byte_position = bump16(st.byte_position, OFFSET_CAP);
            end
        endfunction

        // Compares one accepted result item with the oldest pending token.
        function void check_token(input ctt_pkg::t_out_item got);
            ctt_pkg::t_out_item want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected token: kind %0d start %0d end %0d indent %0d",
                             got.token_kind, got.start_offset, got.end_offset,
                             got.line_indent);
                    $display("  line %0d col %0d fin %0d",
                             got.error_line, got.error_column, got.final_result);
                end
                return;
            end
            want = pending.pop_front();
            if (got.token_kind !== want.token_kind || got.start_offset !== want.start_offset ||
                got.end_offset !== want.end_offset || got.line_indent !== want.line_indent ||
                got.error_line !== want.error_line || got.error_column !== want.error_column ||
                got.final_result !== want.final_result) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Token mismatch, expected kind %0d start %0d end %0d indent %0d",
                             want.token_kind, want.start_offset, want.end_offset,
                             want.line_indent);
                    $display("  expected line %0d col %0d fin %0d",
                             want.error_line, want.error_column, want.final_result);
                    $display("  got kind %0d start %0d end %0d indent %0d",
                             got.token_kind, got.start_offset, got.end_offset,
                             got.line_indent);
                    $display("  got line %0d col %0d fin %0d",
                             got.error_line, got.error_column, got.final_result);
                end
            end
        endfunction
    endclass

endpackage

module config_text_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT     = 2000;
    localparam int unsigned DRAIN_CYCLES    = 20;
    localparam int unsigned ITEMS_PER_PHASE = 80;

    // Sender idle and receiver stall percentages, one pair per phase.
    localparam int unsigned IDLE_PCT [4] = '{0, 51, 0, 38};
    localparam int unsigned STALL_PCT[4] = '{0, 0, 51, 38};

    localparam logic [7:0] MARKS [4] = '{ctt_pkg::CH_LBRACE, ctt_pkg::CH_RBRACE,
                                         ctt_pkg::CH_LBRACK, ctt_pkg::CH_RBRACK};
    localparam logic [7:0] BLANKS[3] = '{ctt_pkg::CH_SPACE, ctt_pkg::CH_TAB, ctt_pkg::CH_CR};
    localparam logic [7:0] QUOTES[3] = '{ctt_pkg::CH_DQUOTE, ctt_pkg::CH_SQUOTE,
                                         ctt_pkg::CH_BTICK};

    logic i_clk = 1'b0;
    logic i_rst_n;

    ctt_in_if  in_if ();
    ctt_out_if out_if ();

    config_text_tokenizer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    ctt_scoreboard_pkg::token_scoreboard sb = new();
    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     bytes_sent     = 0;
    int unsigned     quiet_cycles   = 0;
    logic [7:0]      text_buf[$];

    always #6 i_clk = ~i_clk;

    function automatic bit chance(input int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Random byte different from both given bytes.
    function automatic logic [7:0] pick_byte(input logic [7:0] no_a, input logic [7:0] no_b);
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == no_a || c == no_b)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Random byte that can start a bare key.
    function automatic logic [7:0] key_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (ctt_scoreboard_pkg::ends_key(c) || c == ctt_pkg::CH_BTICK)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic void add_key();
        int unsigned n;
        n = $urandom_range(1, 6);
        text_buf.push_back(key_byte());
        repeat (n - 1)
            text_buf.push_back(chance(12) ? ctt_pkg::CH_BTICK : key_byte());
    endfunction

    // Quoted string or key, with escapes; left open when closed is 0.
    function automatic void add_quoted(input bit closed);
        logic [7:0] q;
        q = QUOTES[$urandom_range(0, 2)];
        text_buf.push_back(q);
        repeat ($urandom_range(0, 6)) begin
            if (chance(17)) begin
                text_buf.push_back(ctt_pkg::CH_BSLASH);
                text_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                text_buf.push_back(pick_byte(q, ctt_pkg::CH_BSLASH));
            end
        end
        if (closed)
            text_buf.push_back(q);
    endfunction

    // One random text: mostly well-formed tokens, some noise and broken endings.
    function automatic void make_text();
        if (chance(20)) begin
            repeat ($urandom_range(1, 12))
                text_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(2, 8)) begin
            case ($urandom_range(0, 9))
                0: begin
                    text_buf.push_back(ctt_pkg::CH_LF);
                    repeat ($urandom_range(0, 4))
                        text_buf.push_back(chance(50) ? ctt_pkg::CH_SPACE : ctt_pkg::CH_TAB);
                end
                1, 2, 7: begin
                    add_key();
                    text_buf.push_back(BLANKS[$urandom_range(0, 2)]);
                end
                3, 8: add_quoted(1'b1);
                4, 9: text_buf.push_back(MARKS[$urandom_range(0, 3)]);
                5: begin
                    text_buf.push_back(ctt_pkg::CH_SEMI);
                    repeat ($urandom_range(0, 5))
                        text_buf.push_back(pick_byte(ctt_pkg::CH_LF, ctt_pkg::CH_LF));
                    text_buf.push_back(ctt_pkg::CH_LF);
                end
                default: text_buf.push_back(BLANKS[$urandom_range(0, 2)]);
            endcase
        end
        // Ending: open quote, open escape, open comment, open key, or clean.
        case ($urandom_range(0, 9))
            0: add_quoted(1'b0);
            1: begin
                add_quoted(1'b0);
                text_buf.push_back(ctt_pkg::CH_BSLASH);
            end
            2: begin
                text_buf.push_back(ctt_pkg::CH_SEMI);
                repeat ($urandom_range(0, 3))
                    text_buf.push_back(pick_byte(ctt_pkg::CH_LF, ctt_pkg::CH_LF));
            end
            3: add_key();
            default: begin
            end
        endcase
    endfunction

    // Drives one input item, called and returning at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (chance(send_idle_pct)) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.data  <= '{char_byte: b, last_byte: last};
        in_if.valid <= 1'b1;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text();
        foreach (text_buf[i])
            send_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    // Receiver back-pressure.
    always @(negedge i_clk)
        out_if.ready <= !chance(recv_stall_pct);

    // Item monitor and stall watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                sb.note_byte(in_if.data.char_byte, in_if.data.last_byte);
            if (out_if.valid && out_if.ready)
                sb.check_token(out_if.data);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("[config_text_tokenizer] ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // All token kinds but TK_UNCLOSED, zero and all-ones key bytes, a backtick inside a key,
        // a comment closed by a newline with indent after it, an escaped quote,
        // an empty quoted key, and a key closed by the final byte's bracket.
        text_buf = '{ctt_pkg::CH_LBRACE, 8'h00, ctt_pkg::CH_BTICK, 8'hFF, ctt_pkg::CH_CR,
                     ctt_pkg::CH_SEMI, ctt_pkg::CH_LF, ctt_pkg::CH_TAB, ctt_pkg::CH_SPACE,
                     ctt_pkg::CH_LBRACK, ctt_pkg::CH_DQUOTE, ctt_pkg::CH_BSLASH,
                     ctt_pkg::CH_DQUOTE, ctt_pkg::CH_DQUOTE, ctt_pkg::CH_SQUOTE, "b",
                     ctt_pkg::CH_SQUOTE, ctt_pkg::CH_BTICK, ctt_pkg::CH_BTICK,
                     ctt_pkg::CH_RBRACE, "k", ctt_pkg::CH_RBRACK};
        send_text();
        // Open quote whose final byte is a backslash.
        text_buf = '{ctt_pkg::CH_SQUOTE, ctt_pkg::CH_BSLASH};
        send_text();
        // Comment still open at the end.
        text_buf = '{ctt_pkg::CH_SEMI};
        send_text();
        // Key still open at the end.
        text_buf = '{"x"};
        send_text();

        // Random texts under each idling pattern.
        for (int p = 0; p < 4; p++) begin
            int unsigned target;
            send_idle_pct  = IDLE_PCT[p];
            recv_stall_pct = STALL_PCT[p];
            target = bytes_sent + ITEMS_PER_PHASE;
            while (bytes_sent < target) begin
                make_text();
                send_text();
            end
        end
        in_if.valid <= 1'b0;
        recv_stall_pct = 0;

        // Drain the remaining tokens, then watch for strays.
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("[config_text_tokenizer] OK");
        else
            $display("[config_text_tokenizer] ERROR");
        $finish;
    end

endmodule
